// ===== src/egd_pkg.sv =====
// shared types and constants for the elgamal decryption block
`timescale 1ns / 1ps

package egd_pkg;

  // width of the ciphertext, key and result words
  localparam int FIELD_W = 31;
  // width of the character output
  localparam int CHAR_W = 8;
  // bit counter of the serial modular multiplier
  localparam int CNT_W = $clog2(FIELD_W);
  // configuration register index
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_KEY = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_MUL,
    S_SQR,
    S_FINAL
  } state_t;

endpackage

// ===== src/elgamal_decrypt.sv =====
// elgamal decryption by square-and-multiply on one bit-serial modular multiplier
`timescale 1ns / 1ps

// channel  ports                                   handshake
// -------  --------------------------------------  ------------------------------------
// input    in_cipher_a, in_cipher_b                word taken when start & !busy
// result   out_plain_value, out_plain_char         out_valid high for one cycle
// config   cfg_index, cfg_wdata                    written on any edge with cfg_we high
//
// the result word follows n modular multiplies: one reduction of a, one per set exponent
// bit, one per squaring and one final multiply by b; n is at most 2 * MOD_BITS, since
// p-1-x never has all MOD_BITS bits set. the shared multiplier retires one bit of its
// 31-bit multiplicand per cycle.
// a zero modulus answers zero in the next cycle, with no multiply.
// reset (synchronous, rst_n low) returns to idle with modulus 257 and key 2.
// busy stays high until the result strobe; the receiver cannot stall the block.

module elgamal_decrypt #(
  parameter int MOD_BITS = 31
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input word
  input  logic                              start,
  output logic                              busy,
  input  logic [egd_pkg::FIELD_W-1:0]       in_cipher_a,
  input  logic [egd_pkg::FIELD_W-1:0]       in_cipher_b,
  // result word
  output logic                              out_valid,
  output logic [egd_pkg::FIELD_W-1:0]       out_plain_value,
  output logic [egd_pkg::CHAR_W-1:0]        out_plain_char,
  // configuration
  input  logic                              cfg_we,
  input  logic [egd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [egd_pkg::FIELD_W-1:0]       cfg_wdata
);

  import egd_pkg::*;

  localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(257);
  localparam logic [FIELD_W-1:0]  KEY_RESET = FIELD_W'(2);

  // configuration registers
  logic [MOD_BITS-1:0] modulus_r, modulus_nxt;
  logic [FIELD_W-1:0]  key_r, key_nxt;

  // sequencer
  state_t state_r, state_nxt;

  // exponent, running power, base and the b operand
  logic [MOD_BITS-1:0] e_r, e_nxt;
  logic [MOD_BITS-1:0] acc_r, acc_nxt;
  logic [MOD_BITS-1:0] base_r, base_nxt;
  logic [FIELD_W-1:0]  b_r, b_nxt;

  // serial modular multiplier: acc = 2*acc + bit*y, reduced mod p each cycle
  logic [FIELD_W-1:0]  mm_x_r, mm_x_nxt;
  logic [MOD_BITS-1:0] mm_y_r, mm_y_nxt;
  logic [MOD_BITS-1:0] mm_acc_r, mm_acc_nxt;
  logic [CNT_W-1:0]    mm_cnt_r, mm_cnt_nxt;

  // result word
  logic                out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]  out_value_r, out_value_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;

  // combinational helpers
  logic [MOD_BITS+1:0] mm_t, mm_p1, mm_p2, mm_red;
  logic [MOD_BITS-1:0] mm_res;
  logic                mm_last;
  logic                accept;
  logic                mod_zero;
  logic [FIELD_W:0]    key_inc;
  logic                key_big;
  logic [MOD_BITS-1:0] e_start;
  logic [MOD_BITS-1:0] e_shift;

  assign accept   = start && (state_r == S_IDLE);
  assign mod_zero = (modulus_r == '0);
  assign mm_last  = (mm_cnt_r == '0);
  assign e_shift  = e_r >> 1;

  // exponent p-1-x, or zero when the key is not below p-1
  assign key_inc = {1'b0, key_r} + (FIELD_W + 1)'(1);
  assign key_big = key_inc >= (FIELD_W + 1)'(modulus_r);
  assign e_start = key_big ? '0 : (modulus_r - MOD_BITS'(1) - key_r[MOD_BITS-1:0]);

  // one multiplier step; acc < p and y <= p keep t below 3p
  always_comb begin
    mm_p1 = {2'b00, modulus_r};
    mm_p2 = {1'b0, modulus_r, 1'b0};
    mm_t  = {1'b0, mm_acc_r, 1'b0} + (mm_x_r[FIELD_W-1] ? {2'b00, mm_y_r} : '0);
    if (mm_t >= mm_p2) begin
      mm_red = mm_t - mm_p2;
    end else if (mm_t >= mm_p1) begin
      mm_red = mm_t - mm_p1;
    end else begin
      mm_red = mm_t;
    end
    mm_res = mm_red[MOD_BITS-1:0];
  end

  // configuration writes
  always_comb begin
    modulus_nxt = modulus_r;
    key_nxt     = key_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:     modulus_nxt = cfg_wdata[MOD_BITS-1:0];
        REG_PRIVATE_KEY: key_nxt     = cfg_wdata;
        default:         ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !mod_zero) begin
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (mm_last) begin
          if (e_r == '0) begin
            state_nxt = S_FINAL;
          end else if (e_r[0]) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_SQR;
          end
        end
      end
      S_MUL: begin
        // square only while higher exponent bits remain
        if (mm_last) begin
          state_nxt = (e_shift == '0) ? S_FINAL : S_SQR;
        end
      end
      S_SQR: begin
        // next exponent bit is e[1] once shifted
        if (mm_last) begin
          state_nxt = e_r[1] ? S_MUL : S_SQR;
        end
      end
      S_FINAL: begin
        if (mm_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result outputs
  always_comb begin
    e_nxt         = e_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    b_nxt         = b_r;
    mm_x_nxt      = mm_x_r << 1;
    mm_y_nxt      = mm_y_r;
    mm_acc_nxt    = mm_res;
    mm_cnt_nxt    = mm_cnt_r - CNT_W'(1);
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_char_nxt  = out_char_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          e_nxt   = e_start;
          acc_nxt = MOD_BITS'(1);
          b_nxt   = in_cipher_b;
          if (mod_zero) begin
            // no residue exists: answer zero at once
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            out_char_nxt  = '0;
          end
        end
      end
      S_REDUCE: begin
        if (mm_last) begin
          base_nxt = mm_res;
        end
      end
      S_MUL: begin
        if (mm_last) begin
          acc_nxt = mm_res;
        end
      end
      S_SQR: begin
        if (mm_last) begin
          base_nxt = mm_res;
          e_nxt    = e_shift;
        end
      end
      S_FINAL: begin
        if (mm_last) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = FIELD_W'(mm_res);
          out_char_nxt  = mm_res[CHAR_W-1:0];
        end
      end
      default: ;
    endcase

    // launch the multiplier for the state about to be entered
    if ((accept && !mod_zero) || (mm_last && state_r != S_IDLE && state_r != S_FINAL)) begin
      mm_acc_nxt = '0;
      mm_cnt_nxt = CNT_W'(FIELD_W - 1);
      unique case (state_nxt)
        S_REDUCE: begin
          // a mod p as a times one
          mm_x_nxt = in_cipher_a;
          mm_y_nxt = MOD_BITS'(1);
        end
        S_MUL: begin
          mm_x_nxt = FIELD_W'(acc_nxt);
          mm_y_nxt = base_nxt;
        end
        S_SQR: begin
          mm_x_nxt = FIELD_W'(base_nxt);
          mm_y_nxt = base_nxt;
        end
        S_FINAL: begin
          // b is not reduced, so it goes in as the scanned operand
          mm_x_nxt = b_r;
          mm_y_nxt = acc_nxt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      modulus_r   <= MOD_RESET;
      key_r       <= KEY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      modulus_r   <= modulus_nxt;
      key_r       <= key_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r         <= e_nxt;
    acc_r       <= acc_nxt;
    base_r      <= base_nxt;
    b_r         <= b_nxt;
    mm_x_r      <= mm_x_nxt;
    mm_y_r      <= mm_y_nxt;
    mm_acc_r    <= mm_acc_nxt;
    mm_cnt_r    <= mm_cnt_nxt;
    out_value_r <= out_value_nxt;
    out_char_r  <= out_char_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_plain_value = out_value_r;
  assign out_plain_char  = out_char_r;

endmodule

// ===== dv/elgamal_decrypt_check.sv =====
// checker for the elgamal decryption block: predicts each result word and compares it
`timescale 1ns / 1ps

module elgamal_decrypt_check #(
  parameter int MOD_BITS = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [egd_pkg::FIELD_W-1:0]   in_cipher_a,
  input  logic [egd_pkg::FIELD_W-1:0]   in_cipher_b,
  input  logic                          out_valid,
  input  logic [egd_pkg::FIELD_W-1:0]   out_plain_value,
  input  logic [egd_pkg::CHAR_W-1:0]    out_plain_char,
  input  logic                          cfg_we,
  input  logic [egd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [egd_pkg::FIELD_W-1:0]   cfg_wdata,
  output int                            mismatch_count,
  output int                            pending_words
);

  import egd_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic [CHAR_W-1:0]  letter;
  } plain_t;

  localparam logic [FIELD_W-1:0] MOD_MASK = FIELD_W'((64'd1 << MOD_BITS) - 1);

  logic [FIELD_W-1:0] modulus_q;
  logic [FIELD_W-1:0] key_q;
  plain_t             plain_q[$];

  // square-and-multiply from the low exponent bit
  function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc  = 64'd1;
    base = base % m;
    for (int i = 0; i < MOD_BITS && e != 0; i++) begin
      if (e[0])
        acc = (acc * base) % m;
      base = (base * base) % m;
      e    = e >> 1;
    end
    return acc;
  endfunction

  function automatic plain_t decrypt_word(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                                          logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] x);
    logic [63:0] pw;
    logic [63:0] xw;
    logic [63:0] mask_pow;
    logic [63:0] v;
    plain_t      w;
    pw = 64'(p);
    xw = 64'(x);
    if (pw == 64'd0) begin
      v = 64'd0;
    end else begin
      // key not below p-1 leaves the power at one
      if (xw + 64'd1 >= pw)
        mask_pow = 64'd1;
      else
        mask_pow = mod_pow(64'(a), pw - 64'd1 - xw, pw);
      v = (64'(b) * mask_pow) % pw;
    end
    w.value  = v[FIELD_W-1:0];
    w.letter = v[CHAR_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    plain_t got;
    plain_t want;
    if (!rst_n) begin
      modulus_q = 31'd257 & MOD_MASK;
      key_q     = 31'd2;
      plain_q.delete();
    end else begin
      if (out_valid) begin
        got.value  = out_plain_value;
        got.letter = out_plain_char;
        if (plain_q.size() == 0) begin
          $display("%0t: result word with none expected: value %0d char %0d",
                   $time, got.value, got.letter);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = plain_q.pop_front();
          if (got != want) begin
            $display("%0t: plain_value expected %0d got %0d, plain_char expected %0d got %0d",
                     $time, want.value, got.value, want.letter, got.letter);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (start && !busy)
        plain_q.push_back(decrypt_word(in_cipher_a, in_cipher_b, modulus_q, key_q));
      if (cfg_we) begin
        if (cfg_index == REG_MODULUS)
          modulus_q = cfg_wdata & MOD_MASK;
        else if (cfg_index == REG_PRIVATE_KEY)
          key_q = cfg_wdata;
      end
    end
    pending_words <= plain_q.size();
  end

  initial begin
    mismatch_count = 0;
    pending_words  = 0;
  end

endmodule

// ===== dv/elgamal_decrypt_test.sv =====
// top of the elgamal decryption testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module elgamal_decrypt_test;
  import egd_pkg::*;

  localparam int                 MOD_BITS  = 31;
  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
  // longest stretch with no word taken: it must outlast a full 31-bit decryption,
  // a long sender gap and the closing wait
  localparam int                 STALL_LIMIT = 20000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [FIELD_W-1:0]   in_cipher_a = '0;
  logic [FIELD_W-1:0]   in_cipher_b = '0;
  logic                 out_valid;
  logic [FIELD_W-1:0]   out_plain_value;
  logic [CHAR_W-1:0]    out_plain_char;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MODULUS;
  logic [FIELD_W-1:0]   cfg_wdata = '0;

  int mismatch_count;
  int pending_words;
  int stall_cycles = 0;
  // chance in a hundred that the sender pauses before a word
  int gap_pct = 20;

  always #2 clk = ~clk;

  elgamal_decrypt #(
    .MOD_BITS(MOD_BITS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cipher_a    (in_cipher_a),
    .in_cipher_b    (in_cipher_b),
    .out_valid      (out_valid),
    .out_plain_value(out_plain_value),
    .out_plain_char (out_plain_char),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  elgamal_decrypt_check #(
    .MOD_BITS(MOD_BITS)
  ) i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cipher_a    (in_cipher_a),
    .in_cipher_b    (in_cipher_b),
    .out_valid      (out_valid),
    .out_plain_value(out_plain_value),
    .out_plain_char (out_plain_char),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words)
  );

  // watchdog: any taken input word or result strobe counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // offer one ciphertext word and hold it until the block takes it;
  // the odd long pause lets the next start land anywhere in a decryption
  task automatic send_word(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
    int gap;
    if ($urandom_range(99) < gap_pct) begin
      if ($urandom_range(3) == 0)
        gap = $urandom_range(2000, 1);
      else
        gap = $urandom_range(8, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_cipher_a <= a;
    in_cipher_b <= b;
    do @(posedge clk); while (busy);
  endtask

  // drop start and wait for every expected word; one word per input, so
  // nothing is still in flight once the count is back at zero
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words != 0 || busy) @(posedge clk);
  endtask

  // registers are only written with the block idle
  task automatic configure(input logic [FIELD_W-1:0] p, input logic [FIELD_W-1:0] x);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MODULUS;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_index <= REG_PRIVATE_KEY;
    cfg_wdata <= x;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly moduli up to 16 bits to keep decryptions short, with the
  // full-width and degenerate ones mixed in
  function automatic logic [FIELD_W-1:0] pick_modulus();
    case ($urandom_range(9))
      0:       return FIELD_MAX;
      1:       return 31'd257;
      2:       return FIELD_W'($urandom_range(256, 0));
      3, 4:    return FIELD_W'($urandom);
      default: return FIELD_W'($urandom_range(65535, 257));
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pick_key(input logic [FIELD_W-1:0] p);
    logic [31:0] pw;
    pw = 32'(p);
    case ($urandom_range(7))
      0:       return FIELD_W'(pw - 1);
      1:       return FIELD_MAX;
      2:       return '0;
      3:       return FIELD_W'(pw - 2);
      default: return (pw > 1) ? FIELD_W'($urandom_range(pw - 1, 0)) : FIELD_W'($urandom);
    endcase
  endfunction

  // cipher_a near the modulus checks the reduction before the power
  function automatic logic [FIELD_W-1:0] pick_cipher_a(input logic [FIELD_W-1:0] p);
    case ($urandom_range(9))
      0:       return '0;
      1:       return FIELD_MAX;
      2:       return p;
      3:       return p - 1'b1;
      4:       return 31'd1;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pick_cipher_b();
    case ($urandom_range(9))
      0:       return '0;
      1:       return FIELD_MAX;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [FIELD_W-1:0] p;
    logic [FIELD_W-1:0] x;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: modulus 257, key 2
    send_word('0, '0);
    send_word(FIELD_MAX, FIELD_MAX);
    send_word(31'd3, 31'd100);

    // largest modulus, exponent close to full width; a equal to p reduces to zero
    configure(FIELD_MAX, 31'd1);
    send_word(FIELD_MAX, 31'd12345);
    send_word(FIELD_MAX - 1'b1, FIELD_MAX);
    send_word(31'd2, 31'd1);
    configure(FIELD_MAX, '0);
    send_word(31'd3, 31'd7);
    // exponent of one
    configure(FIELD_MAX, FIELD_MAX - 31'd2);
    send_word(FIELD_MAX - 1'b1, FIELD_MAX - 1'b1);
    // key equal to p-1 and key above p: power taken as one
    configure(FIELD_MAX, FIELD_MAX - 1'b1);
    send_word(31'd5, FIELD_MAX);
    configure(31'd257, FIELD_MAX);
    send_word(31'd9, 31'd1000);
    // modulus of one and of zero both answer zero
    configure(31'd1, '0);
    send_word(FIELD_MAX, FIELD_MAX);
    configure('0, 31'd5);
    send_word(31'd7, FIELD_MAX);
    // power-of-two modulus and the smallest non-trivial one
    configure(31'h4000_0000, 31'd12345);
    send_word(FIELD_MAX, FIELD_MAX);
    configure(31'd2, '0);
    send_word(31'd1, 31'd1);

    // random part: sender pauses at 20 in a hundred, then 66, then never
    for (int mode = 0; mode < 3; mode++) begin
      gap_pct = (mode == 0) ? 20 : (mode == 1) ? 66 : 0;
      for (int phase = 0; phase < 4; phase++) begin
        p = pick_modulus();
        x = pick_key(p);
        configure(p, x);
        repeat (24) send_word(pick_cipher_a(p), pick_cipher_b());
      end
    end

    drain();
    // room for any stray strobe after the last expected word
    repeat (2100) @(posedge clk);
    if (mismatch_count == 0 && pending_words == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/egd_pkg.sv
src/elgamal_decrypt.sv
dv/elgamal_decrypt_check.sv
dv/elgamal_decrypt_test.sv
